[rtl/bsp_pkg.sv]
// shared constants, types and control structs of the bidirectional shortest path core
`default_nettype none
package bsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 22;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = VIDX_W + 1;
  localparam int EADDR_W      = 2 * VIDX_W;
  localparam int EDGE_W       = 16;
  localparam int CFG_W        = 7;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 40;

  localparam logic [DIST_BITS-1:0] UNREACHED = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {RD_IDX, RD_CU, RD_CUR} rd_sel_e;
  typedef enum logic [1:0] {OUT_FAIL, OUT_SAME, OUT_POP, OUT_BK} out_sel_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_QCHK, ST_INIT, ST_SCAN, ST_SCAN_END, ST_EVAL, ST_OREAD,
    ST_MEET, ST_RELAX, ST_RELAX_END, ST_NEXT, ST_CH_TEST, ST_CH_RD, ST_CH_PUSH,
    ST_POP_RD, ST_POP_TAKE, ST_POP_RD2, ST_POP_OUT, ST_BK_TEST, ST_BK_RD,
    ST_BK_STEP, ST_BK_RD2, ST_BK_OUT, ST_FAIL, ST_SAME
  } state_e;

  typedef struct packed {
    logic     in_ready;
    logic     clr_step;
    logic     init;
    logic     scan_init;
    logic     scan_issue;
    logic     set_last;
    logic     set_empty;
    logic     side_flip;
    logic     meet_upd;
    logic     relax_issue;
    logic     ch_init;
    logic     ch_push;
    logic     pop_take;
    logic     bk_init;
    logic     bk_step;
    logic     out_load;
    out_sel_e out_sel;
    rd_sel_e  rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_query;
    logic clr_last;
    logic q_bad;
    logic q_same;
    logic idx_last;
    logic cand;
    logic stop;
    logic side;
    logic a_empty;
    logic met;
    logic ch_more;
    logic len_zero;
    logic bk_more;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/bsp_ctrl.sv]
// controller state machine sequencing clear, search, path walk and result emission
`default_nettype none
module bsp_ctrl
  import bsp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.rd_sel = RD_CUR;
    cmd_o.out_sel = OUT_FAIL;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_query) state_d = ST_QCHK;
      end
      ST_QCHK: begin
        if (sts_i.q_bad) state_d = ST_FAIL;
        else if (sts_i.q_same) state_d = ST_SAME;
        else state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.rd_sel = RD_IDX;
        cmd_o.scan_issue = 1'b1;
        if (sts_i.idx_last) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: state_d = ST_EVAL;
      ST_EVAL: begin
        if (!sts_i.side) cmd_o.set_empty = 1'b1;
        if (!sts_i.cand) begin
          if (sts_i.side && sts_i.a_empty) begin
            if (sts_i.met) begin
              cmd_o.ch_init = 1'b1;
              state_d = ST_CH_TEST;
            end else begin
              state_d = ST_FAIL;
            end
          end else begin
            cmd_o.side_flip = 1'b1;
            cmd_o.scan_init = 1'b1;
            state_d = ST_SCAN;
          end
        end else begin
          cmd_o.set_last = 1'b1;
          if (sts_i.stop) begin
            cmd_o.ch_init = 1'b1;
            state_d = ST_CH_TEST;
          end else begin
            state_d = ST_OREAD;
          end
        end
      end
      ST_OREAD: begin
        cmd_o.rd_sel = RD_CU;
        state_d = ST_MEET;
      end
      ST_MEET: begin
        cmd_o.rd_sel = RD_CU;
        cmd_o.meet_upd = 1'b1;
        state_d = ST_RELAX;
      end
      ST_RELAX: begin
        cmd_o.rd_sel = RD_IDX;
        cmd_o.relax_issue = 1'b1;
        if (sts_i.idx_last) state_d = ST_RELAX_END;
      end
      ST_RELAX_END: state_d = ST_NEXT;
      ST_NEXT: begin
        cmd_o.side_flip = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d = ST_SCAN;
      end
      ST_CH_TEST: begin
        if (sts_i.ch_more) state_d = ST_CH_RD;
        else state_d = ST_POP_RD;
      end
      ST_CH_RD: state_d = ST_CH_PUSH;
      ST_CH_PUSH: begin
        cmd_o.ch_push = 1'b1;
        state_d = ST_CH_TEST;
      end
      ST_POP_RD: state_d = ST_POP_TAKE;
      ST_POP_TAKE: begin
        cmd_o.pop_take = 1'b1;
        state_d = ST_POP_RD2;
      end
      ST_POP_RD2: state_d = ST_POP_OUT;
      ST_POP_OUT: begin
        cmd_o.out_sel = OUT_POP;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!sts_i.len_zero) begin
            state_d = ST_POP_RD;
          end else begin
            cmd_o.bk_init = 1'b1;
            state_d = ST_BK_TEST;
          end
        end
      end
      ST_BK_TEST: begin
        if (sts_i.bk_more) state_d = ST_BK_RD;
        else state_d = ST_IDLE;
      end
      ST_BK_RD: state_d = ST_BK_STEP;
      ST_BK_STEP: begin
        cmd_o.bk_step = 1'b1;
        state_d = ST_BK_RD2;
      end
      ST_BK_RD2: state_d = ST_BK_OUT;
      ST_BK_OUT: begin
        cmd_o.out_sel = OUT_BK;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_BK_TEST;
        end
      end
      ST_FAIL: begin
        cmd_o.out_sel = OUT_FAIL;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SAME: begin
        cmd_o.out_sel = OUT_SAME;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/bsp_datapath.sv]
// datapath: edge matrix, distance and parent stores, search registers, result register
`default_nettype none
module bsp_datapath
  import bsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o,
  output logic                  m_axis_tlast_o,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o
);

  logic [EDGE_W-1:0]    edge_mem [2**EADDR_W];
  logic [DIST_BITS-1:0] fdist_mem [MAX_VERTICES];
  logic [DIST_BITS-1:0] bdist_mem [MAX_VERTICES];
  logic [VIDX_W-1:0]    fpar_mem [MAX_VERTICES];
  logic [VIDX_W-1:0]    bpar_mem [MAX_VERTICES];
  logic [VIDX_W-1:0]    chain_mem [MAX_VERTICES];

  logic [VCNT_W-1:0]       n_q;
  logic [EADDR_W-1:0]      clr_q;
  logic [VIDX_W-1:0]       s_q, e_q, idx_q, ra_q, cu_q, cur_q, prv_q, meet_q;
  logic                    side_q, met_q, cand_q, a_empty_q, pv_scan_q, pv_rlx_q;
  logic [MAX_VERTICES-1:0] fval_q, bval_q, fdone_q, bdone_q;
  logic [DIST_BITS-1:0]    cd_q, last_f_q, last_b_q;
  logic [DIST_BITS:0]      best_q;
  logic [VCNT_W-1:0]       len_q, k_q;
  logic [EDGE_W-1:0]       ed_rd_q;
  logic [DIST_BITS-1:0]    fd_rd_q, bd_rd_q;
  logic [VIDX_W-1:0]       fp_rd_q, bp_rd_q, ch_rd_q;
  logic [VIDX_W-1:0]       ov_q, op_q;
  logic [DIST_BITS-1:0]    od_q;
  logic                    of_q, ol_q, out_v_q;

  logic [VIDX_W-1:0]       in_from, in_to, in_start, in_end, raddr;
  logic [EDGE_W-1:0]       in_weight;
  logic                    in_acc, in_wr;
  logic [DIST_BITS-1:0]    fdv, bdv, own_dv, oth_dv, other_last;
  logic                    own_done, own_val;
  logic [DIST_BITS:0]      nd, total, stop_sum;
  logic                    rlx_wr, scan_hit;
  logic                    e_we, fd_we, bd_we;
  logic [EADDR_W-1:0]      e_wa, e_ra;
  logic [EDGE_W-1:0]       e_wd;
  logic [VIDX_W-1:0]       fd_wa, bd_wa, fp_wd, bp_wd;
  logic [DIST_BITS-1:0]    fd_wd, bd_wd;
  logic [VCNT_W:0]         k_next;
  logic                    bk_after;
  logic [VIDX_W-1:0]       nv;
  logic [DIST_BITS-1:0]    nd_out;
  logic [VIDX_W-1:0]       np_out;
  logic                    nf_out, nl_out;

  assign in_from   = s_axis_tdata_i[5:0];
  assign in_to     = s_axis_tdata_i[11:6];
  assign in_weight = s_axis_tdata_i[27:12] & EDGE_W'((1 << WEIGHT_BITS) - 1);
  assign in_start  = s_axis_tdata_i[33:28];
  assign in_end    = s_axis_tdata_i[39:34];
  assign in_acc    = s_axis_tvalid_i && cmd_i.in_ready;
  assign in_wr     = in_acc && (s_axis_tuser_i == OP_WRITE);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:  raddr = idx_q;
      RD_CU:   raddr = cu_q;
      default: raddr = cur_q;
    endcase
  end

  assign fdv = fval_q[ra_q] ? fd_rd_q : UNREACHED;
  assign bdv = bval_q[ra_q] ? bd_rd_q : UNREACHED;
  assign own_dv     = side_q ? bdv : fdv;
  assign oth_dv     = side_q ? fdv : bdv;
  assign own_done   = side_q ? bdone_q[ra_q] : fdone_q[ra_q];
  assign own_val    = side_q ? bval_q[ra_q] : fval_q[ra_q];
  assign other_last = side_q ? last_f_q : last_b_q;

  assign scan_hit = pv_scan_q && !own_done && own_val && (!cand_q || own_dv < cd_q);
  assign nd       = {1'b0, cd_q} + (DIST_BITS + 1)'(ed_rd_q);
  assign rlx_wr   = pv_rlx_q && (ed_rd_q != '0) && (nd < {1'b0, UNREACHED})
                    && (nd < {1'b0, own_dv});
  assign total    = {1'b0, cd_q} + {1'b0, oth_dv};
  assign stop_sum = {1'b0, cd_q} + {1'b0, other_last};

  // edge matrix, cleared once after reset
  assign e_we = cmd_i.clr_step || in_wr;
  assign e_wa = cmd_i.clr_step ? clr_q : {in_from, in_to};
  assign e_wd = cmd_i.clr_step ? '0 : in_weight;
  assign e_ra = side_q ? {idx_q, cu_q} : {cu_q, idx_q};

  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    ed_rd_q <= edge_mem[e_ra];
  end

  assign fd_we = cmd_i.init || (rlx_wr && !side_q);
  assign bd_we = cmd_i.init || (rlx_wr && side_q);
  assign fd_wa = cmd_i.init ? s_q : ra_q;
  assign bd_wa = cmd_i.init ? e_q : ra_q;
  assign fd_wd = cmd_i.init ? '0 : nd[DIST_BITS-1:0];
  assign bd_wd = fd_wd;
  assign fp_wd = cmd_i.init ? s_q : cu_q;
  assign bp_wd = cmd_i.init ? e_q : cu_q;

  always_ff @(posedge clk_i) begin
    if (fd_we) begin
      fdist_mem[fd_wa] <= fd_wd;
      fpar_mem[fd_wa]  <= fp_wd;
    end
    if (bd_we) begin
      bdist_mem[bd_wa] <= bd_wd;
      bpar_mem[bd_wa]  <= bp_wd;
    end
    fd_rd_q <= fdist_mem[raddr];
    bd_rd_q <= bdist_mem[raddr];
    fp_rd_q <= fpar_mem[raddr];
    bp_rd_q <= bpar_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ch_init) chain_mem[0] <= meet_q;
    else if (cmd_i.ch_push) chain_mem[len_q[VIDX_W-1:0]] <= fp_rd_q;
    ch_rd_q <= chain_mem[VIDX_W'(len_q - VCNT_W'(1))];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= VCNT_W'(MAX_VERTICES);
      clr_q     <= '0;
      side_q    <= 1'b0;
      met_q     <= 1'b0;
      cand_q    <= 1'b0;
      a_empty_q <= 1'b0;
      pv_scan_q <= 1'b0;
      pv_rlx_q  <= 1'b0;
      fval_q    <= '0;
      bval_q    <= '0;
      fdone_q   <= '0;
      bdone_q   <= '0;
      idx_q     <= '0;
      len_q     <= '0;
      k_q       <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) n_q <= VCNT_W'(1);
        else if (cfg_wdata_i > CFG_W'(MAX_VERTICES)) n_q <= VCNT_W'(MAX_VERTICES);
        else n_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) clr_q <= clr_q + EADDR_W'(1);
      pv_scan_q <= cmd_i.scan_issue;
      pv_rlx_q  <= cmd_i.relax_issue;
      if (cmd_i.scan_issue || cmd_i.relax_issue) idx_q <= idx_q + VIDX_W'(1);
      if (cmd_i.scan_init || cmd_i.meet_upd) idx_q <= '0;
      if (cmd_i.scan_init) cand_q <= 1'b0;
      else if (scan_hit) cand_q <= 1'b1;
      if (cmd_i.set_empty) a_empty_q <= !cand_q;
      if (cmd_i.side_flip) side_q <= !side_q;
      if (rlx_wr) begin
        if (side_q) bval_q[ra_q] <= 1'b1;
        else fval_q[ra_q] <= 1'b1;
      end
      if (cmd_i.meet_upd) begin
        if (oth_dv != UNREACHED && (!met_q || total < best_q)) met_q <= 1'b1;
        if (side_q) bdone_q[cu_q] <= 1'b1;
        else fdone_q[cu_q] <= 1'b1;
      end
      if (cmd_i.init) begin
        side_q    <= 1'b0;
        met_q     <= 1'b0;
        a_empty_q <= 1'b0;
        fdone_q   <= '0;
        bdone_q   <= '0;
        fval_q    <= '0;
        bval_q    <= '0;
        fval_q[s_q] <= 1'b1;
        bval_q[e_q] <= 1'b1;
      end
      if (cmd_i.ch_init) begin
        len_q <= VCNT_W'(1);
        k_q   <= '0;
      end
      if (cmd_i.ch_push) len_q <= len_q + VCNT_W'(1);
      if (cmd_i.pop_take) len_q <= len_q - VCNT_W'(1);
      if (cmd_i.out_load && (cmd_i.out_sel == OUT_POP || cmd_i.out_sel == OUT_BK)) begin
        k_q <= k_q + VCNT_W'(1);
      end
      if (cmd_i.out_load) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ra_q <= raddr;
    if (in_acc && s_axis_tuser_i == OP_QUERY) begin
      s_q <= in_start;
      e_q <= in_end;
    end
    if (scan_hit) begin
      cd_q <= own_dv;
      cu_q <= ra_q;
    end
    if (cmd_i.init) begin
      best_q   <= {1'b0, UNREACHED};
      meet_q   <= '0;
      last_f_q <= '0;
      last_b_q <= '0;
    end
    if (cmd_i.set_last) begin
      if (side_q) last_b_q <= cd_q;
      else last_f_q <= cd_q;
    end
    if (cmd_i.meet_upd && oth_dv != UNREACHED && (!met_q || total < best_q)) begin
      best_q <= total;
      meet_q <= cu_q;
    end
    if (cmd_i.ch_init) cur_q <= meet_q;
    if (cmd_i.ch_push) cur_q <= fp_rd_q;
    if (cmd_i.pop_take) cur_q <= ch_rd_q;
    if (cmd_i.bk_init) cur_q <= meet_q;
    if (cmd_i.bk_step) begin
      prv_q <= cur_q;
      cur_q <= bp_rd_q;
    end
    if (cmd_i.out_load) begin
      ov_q <= nv;
      od_q <= nd_out;
      op_q <= np_out;
      of_q <= nf_out;
      ol_q <= nl_out;
    end
  end

  assign k_next   = {1'b0, k_q} + (VCNT_W + 1)'(1);
  assign bk_after = (meet_q != e_q) && (k_next < {1'b0, n_q});

  always_comb begin
    case (cmd_i.out_sel)
      OUT_SAME: begin
        nv = s_q; nd_out = '0; np_out = s_q; nf_out = 1'b1; nl_out = 1'b1;
      end
      OUT_POP: begin
        nv     = cur_q;
        nd_out = (cur_q == s_q) ? '0 : fdv;
        np_out = (cur_q == s_q) ? s_q : fp_rd_q;
        nf_out = 1'b1;
        nl_out = (len_q == '0) && !bk_after;
      end
      OUT_BK: begin
        nv     = cur_q;
        nd_out = best_q[DIST_BITS-1:0] - bdv;
        np_out = prv_q;
        nf_out = 1'b1;
        nl_out = !((cur_q != e_q) && (k_next < {1'b0, n_q}));
      end
      default: begin
        nv = '0; nd_out = '0; np_out = '0; nf_out = 1'b0; nl_out = 1'b1;
      end
    endcase
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - 2 * VIDX_W - DIST_BITS)'(0), op_q, od_q, ov_q};
  assign m_axis_tuser_o  = of_q;
  assign m_axis_tlast_o  = ol_q;

  assign sts_o.in_query = s_axis_tvalid_i && (s_axis_tuser_i == OP_QUERY);
  assign sts_o.clr_last = &clr_q;
  assign sts_o.q_bad    = ({1'b0, s_q} >= n_q) || ({1'b0, e_q} >= n_q);
  assign sts_o.q_same   = (s_q == e_q);
  assign sts_o.idx_last = ({1'b0, idx_q} == n_q - VCNT_W'(1));
  assign sts_o.cand     = cand_q;
  assign sts_o.stop     = met_q && (stop_sum >= best_q);
  assign sts_o.side     = side_q;
  assign sts_o.a_empty  = a_empty_q;
  assign sts_o.met      = met_q;
  assign sts_o.ch_more  = (cur_q != s_q) && (len_q < n_q);
  assign sts_o.len_zero = (len_q == '0);
  assign sts_o.bk_more  = (cur_q != e_q) && (k_q < n_q);
  assign sts_o.out_free = !out_v_q || m_axis_tready_i;

endmodule
`default_nettype wire

[rtl/bidirectional_shortest_path_core.sv]
// top level of the bidirectional shortest path core
`default_nettype none
// Holds a 64x64 matrix of directed edge weights (0 = no edge) and answers path queries.
// A transaction with tuser 0 writes one weight; tuser 1 runs a query that alternates
// forward and backward settles and then streams the path start to end, one result per
// vertex, tlast on the final one. Each settle is a scan of the n vertices in use followed
// by a relaxation sweep over one matrix row or column through the single read port of
// the edge memory. After reset the edge memory is cleared one entry per cycle while no
// input transaction is accepted.
module bidirectional_shortest_path_core
  import bsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,     // vertex_count
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // from_vertex, to_vertex, edge_weight, path origin, path target
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,  // operation
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // path_vertex, distance_from_start, previous_vertex, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o,  // found
  output logic                  m_axis_tlast_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bsp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bsp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  assign s_axis_tready_o = cmd.in_ready;

`ifndef ASSERT_OFF
  a_query_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OP_QUERY |=> !s_axis_tready_o)
    else $error("input accepted right after a query transaction");

  a_not_found_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("not-found result without tlast");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("activity during edge memory clear");
`endif

endmodule
`default_nettype wire

[tb/bsp_checker.sv]
// checker: predicts the path results of the shortest path core and compares them
module bsp_checker
  import bsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic                  m_axis_tuser_i,
  input  logic                  m_axis_tlast_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [VIDX_W-1:0]    vertex;
    logic [DIST_BITS-1:0] path_dist;
    logic [VIDX_W-1:0]    prev;
    logic                 found;
    logic                 last;
  } path_rec_t;

  localparam int unsigned UNR = (1 << DIST_BITS) - 1;

  logic [EDGE_W-1:0] edge_weights [MAX_VERTICES*MAX_VERTICES];
  logic [CFG_W-1:0]  vertex_count;
  path_rec_t         expected_path [$];

  // side 0 forward, side 1 backward
  int unsigned dist_tab [2][MAX_VERTICES];
  int unsigned par_tab  [2][MAX_VERTICES];
  bit          done_tab [2][MAX_VERTICES];
  int unsigned last_pop [2];
  int unsigned best_total, meet_vertex, used_n;
  bit          met;

  task automatic settle_side(input int side, output int res);
    int unsigned u, d, w, nd, total;
    u = used_n;
    d = UNR;
    for (int i = 0; i < used_n; i++)
      if (!done_tab[side][i] && dist_tab[side][i] != UNR
          && (u == used_n || dist_tab[side][i] < d)) begin
        u = i;
        d = dist_tab[side][i];
      end
    if (u == used_n) begin
      res = 0;
      return;
    end
    last_pop[side] = d;
    if (met && d + last_pop[1-side] >= best_total) begin
      res = 2;
      return;
    end
    if (dist_tab[1-side][u] != UNR) begin
      total = d + dist_tab[1-side][u];
      if (!met || total < best_total) begin
        best_total = total;
        meet_vertex = u;
        met = 1;
      end
    end
    done_tab[side][u] = 1;
    for (int i = 0; i < used_n; i++) begin
      w = (side == 0) ? edge_weights[u*MAX_VERTICES+i] : edge_weights[i*MAX_VERTICES+u];
      if (w == 0) continue;
      nd = d + w;
      if (nd >= UNR) continue;
      if (nd < dist_tab[side][i]) begin
        dist_tab[side][i] = nd;
        par_tab[side][i] = u;
      end
    end
    res = 1;
  endtask

  task automatic predict_path(input int unsigned s, input int unsigned e);
    int a, b, len, k;
    int unsigned cur;
    int unsigned chain [MAX_VERTICES];
    path_rec_t rec;
    used_n = (vertex_count == 0) ? 1
           : (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
    for (int i = 0; i < MAX_VERTICES; i++)
      for (int sd = 0; sd < 2; sd++) begin
        dist_tab[sd][i] = UNR;
        done_tab[sd][i] = 0;
      end
    best_total = UNR;
    meet_vertex = 0;
    met = 0;
    last_pop[0] = 0;
    last_pop[1] = 0;
    if (s >= used_n || e >= used_n || s == e) begin
      rec = '0;
      rec.last = 1;
      if (s == e && s < used_n) begin
        rec.vertex = VIDX_W'(s);
        rec.prev = VIDX_W'(s);
        rec.found = 1;
      end
      expected_path.push_back(rec);
      return;
    end
    dist_tab[0][s] = 0;
    par_tab[0][s] = s;
    dist_tab[1][e] = 0;
    par_tab[1][e] = e;
    forever begin
      settle_side(0, a);
      if (a == 2) break;
      settle_side(1, b);
      if (b == 2) break;
      if (a == 0 && b == 0) break;
    end
    if (!met) begin
      rec = '0;
      rec.last = 1;
      expected_path.push_back(rec);
      return;
    end
    len = 0;
    k = 0;
    cur = meet_vertex;
    chain[len++] = cur;
    while (cur != s && len < used_n) begin
      cur = par_tab[0][cur % MAX_VERTICES];
      chain[len++] = cur;
    end
    while (len > 0 && k < MAX_VERTICES) begin
      cur = chain[--len];
      rec.vertex = VIDX_W'(cur);
      rec.path_dist = (cur == s) ? '0 : DIST_BITS'(dist_tab[0][cur]);
      rec.prev = (cur == s) ? VIDX_W'(s) : VIDX_W'(par_tab[0][cur]);
      rec.found = 1;
      rec.last = 0;
      expected_path.push_back(rec);
      k++;
    end
    cur = meet_vertex;
    while (cur != e && k < MAX_VERTICES && k < used_n) begin
      rec.vertex = VIDX_W'(par_tab[1][cur % MAX_VERTICES]);
      rec.path_dist = DIST_BITS'(best_total - dist_tab[1][rec.vertex]);
      rec.prev = VIDX_W'(cur);
      rec.found = 1;
      rec.last = 0;
      expected_path.push_back(rec);
      cur = rec.vertex;
      k++;
    end
    expected_path[expected_path.size()-1].last = 1;
  endtask

  function automatic int check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp, act);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    fail_count_o = 0;
    vertex_count = CFG_W'(MAX_VERTICES);
    for (int i = 0; i < MAX_VERTICES*MAX_VERTICES; i++) edge_weights[i] = '0;
  end

  always @(posedge clk_i) begin
    path_rec_t exp_rec;
    int errs;
    if (rst_ni) begin
      if (cfg_we_i) vertex_count = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == OP_WRITE)
          edge_weights[{s_axis_tdata_i[5:0], s_axis_tdata_i[11:6]}] = s_axis_tdata_i[27:12];
        else
          predict_path(s_axis_tdata_i[33:28], s_axis_tdata_i[39:34]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_path.size() == 0) begin
          $display("%0t unexpected result tdata %h", $time, m_axis_tdata_i);
          fail_count_o++;
        end else begin
          exp_rec = expected_path.pop_front();
          errs = check_field("path_vertex", 32'(exp_rec.vertex), 32'(m_axis_tdata_i[5:0]))
               + check_field("distance", 32'(exp_rec.path_dist), 32'(m_axis_tdata_i[27:6]))
               + check_field("previous_vertex", 32'(exp_rec.prev),
                             32'(m_axis_tdata_i[33:28]))
               + check_field("found", 32'(exp_rec.found), 32'(m_axis_tuser_i))
               + check_field("last", 32'(exp_rec.last), 32'(m_axis_tlast_i));
          if (errs != 0) fail_count_o++;
        end
      end
    end
    pending_o = expected_path.size();
  end

endmodule

[tb/tb_top.sv]
// testbench top: drives the shortest path core and reports the verdict
module tb_top;
  import bsp_pkg::*;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_we = 0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 0;
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  hold = 0;
  int                    fail_count, pending, burst_left, cycle_count = 0;
  int                    stall_mode = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  bidirectional_shortest_path_core dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast)
  );

  bsp_checker chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata), .m_axis_tuser_i(m_tuser), .m_axis_tlast_i(m_tlast),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall pattern, mode redrawn at random from three patterns
  always @(posedge clk_i) begin
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold) m_tready <= 0;
    else if (stall_mode == 0) m_tready <= 1;
    else if (stall_mode == 1) m_tready <= 1'($urandom_range(0, 1));
    else m_tready <= ($urandom_range(0, 3) == 0);
  end

  task automatic send_item(input logic op, input logic [5:0] from_v, input logic [5:0] to_v,
                           input logic [15:0] weight, input logic [5:0] start_v,
                           input logic [5:0] end_v);
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {end_v, start_v, weight, to_v, from_v};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_item(input int n, input int query_pct);
    logic [5:0] a, b;
    logic [15:0] w;
    int r;
    r = $urandom_range(0, 99);
    a = (r < 85) ? 6'($urandom_range(0, n - 1)) : 6'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    b = (r < 85) ? 6'($urandom_range(0, n - 1)) : 6'($urandom_range(0, 63));
    r = $urandom_range(0, 9);
    if (r == 0) w = 16'h0000;
    else if (r == 1) w = 16'hffff;
    else if (r < 7) w = 16'($urandom_range(1, 20));
    else w = 16'($urandom_range(1, 65535));
    if ($urandom_range(0, 99) < query_pct)
      send_item(OP_QUERY, 6'($urandom), 6'($urandom), 16'($urandom), a, b);
    else
      send_item(OP_WRITE, a, b, w, 6'($urandom), 6'($urandom));
  endtask

  initial begin
    int cfg_list [9];
    int n, qpct;
    cfg_list = '{0, 1, 2, 8, 5, 127, 100, 12, 64};
    burst_left = 4;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    // directed: chains, ties, extremes, same and unreachable endpoints
    send_item(OP_WRITE, 0, 1, 16'hffff, 0, 0);
    send_item(OP_WRITE, 1, 2, 1, 0, 0);
    send_item(OP_WRITE, 63, 63, 16'hffff, 6'h3f, 6'h3f);
    send_item(OP_QUERY, 0, 0, 0, 0, 2);
    send_item(OP_QUERY, 6'h3f, 6'h3f, 16'hffff, 5, 5);
    send_item(OP_QUERY, 0, 0, 0, 0, 63);
    send_item(OP_QUERY, 0, 0, 0, 2, 0);
    send_item(OP_WRITE, 3, 4, 2, 0, 0);
    send_item(OP_WRITE, 3, 5, 1, 0, 0);
    send_item(OP_WRITE, 5, 4, 1, 0, 0);
    send_item(OP_WRITE, 3, 6, 1, 0, 0);
    send_item(OP_WRITE, 6, 4, 1, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 3, 4);
    send_item(OP_WRITE, 62, 61, 16'h8000, 0, 0);
    send_item(OP_WRITE, 61, 0, 16'h7fff, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 62, 2);
    send_item(OP_QUERY, 0, 0, 0, 63, 0);
    send_item(OP_WRITE, 0, 1, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 62, 2);
    wait_idle();
    for (int p = 0; p < 9; p++) begin
      cfg_we <= 1;
      cfg_wdata <= CFG_W'(cfg_list[p]);
      @(posedge clk_i);
      cfg_we <= 0;
      n = (cfg_list[p] == 0) ? 1 : (cfg_list[p] > 64) ? 64 : cfg_list[p];
      qpct = (n > 16) ? 8 : 25;
      if (p == 3) fork
        begin
          hold <= 1;
          repeat (4000) @(posedge clk_i);
          hold <= 0;
        end
      join_none
      for (int i = 0; i < 45; i++) begin
        if (p == 4 && i == 20) begin
          s_tvalid <= 0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        random_item(n, qpct);
      end
      wait_idle();
    end
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
